// ===== hdl/line_edit_buffer_core_defines.svh =====
// Assertion helpers for the line edit buffer. Both sample on clk_i and are
// off while rst_ni is low.
`ifndef LINE_EDIT_BUFFER_CORE_DEFINES_SVH
`define LINE_EDIT_BUFFER_CORE_DEFINES_SVH

// cons must hold in the same cycle as ante
`define LEB_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// cons must hold in the cycle after ante
`define LEB_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/leb_pkg.sv =====
package leb_pkg;

  localparam int CAP_MAX       = 255;  // length field is 8 bits
  localparam int BUF_DEPTH_DEF = 256;

  localparam logic [1:0] STAT_EDIT    = 2'd0;
  localparam logic [1:0] STAT_ENTER   = 2'd1;
  localparam logic [1:0] STAT_ESC     = 2'd2;
  localparam logic [1:0] STAT_IGNORED = 2'd3;

  typedef enum logic [3:0] {
    ACT_CLEAR    = 4'd0,
    ACT_PRELOAD  = 4'd1,
    ACT_TYPE     = 4'd2,
    ACT_LEFT     = 4'd3,
    ACT_RIGHT    = 4'd4,
    ACT_HOME     = 4'd5,
    ACT_END      = 4'd6,
    ACT_BKSP     = 4'd7,
    ACT_DEL      = 4'd8,
    ACT_TOGGLE   = 4'd9,
    ACT_ENTER    = 4'd10,
    ACT_ESC      = 4'd11,
    ACT_READ     = 4'd12
  } act_e;

  // What the commit cycle does to the line state
  typedef enum logic [3:0] {
    OP_IGNORE,
    OP_KEEP,
    OP_CLEAR,
    OP_READ,
    OP_APPEND,
    OP_TYPE_INS,
    OP_TYPE_OVR,
    OP_LEFT,
    OP_RIGHT,
    OP_HOME,
    OP_END,
    OP_BKSP,
    OP_DEL,
    OP_TOGGLE,
    OP_ENTER,
    OP_ESC
  } op_e;

  typedef enum logic [1:0] {
    SH_NONE,
    SH_INSERT,
    SH_DELETE,
    SH_BKSP
  } shift_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_SHIFT,
    S_COMMIT
  } fsm_e;

  typedef struct packed {
    logic       take;         // load item registers
    logic       rd_item;      // read store at item index
    logic       shift_start;
    shift_e     shift_kind;
    logic       commit;       // update line state, load result
    op_e        op;
  } cmd_t;

  typedef struct packed {
    logic [3:0] act;
    logic       ch_zero;
    logic       full;
    logic       at_end;
    logic       pos_zero;
    logic       done;
    logic       ins;
    logic       busy;         // shift engine running
    logic [7:0] pos;
    logic [7:0] len;
  } sts_t;

endpackage

// ===== hdl/leb_dp.sv =====
module leb_dp
  import leb_pkg::*;
#(
  parameter int BUF_DEPTH = BUF_DEPTH_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  cmd_t        cmd_i,
  output sts_t        sts_o,
  input  logic [7:0]  max_len_i,
  input  logic [3:0]  item_act_i,
  input  logic [7:0]  item_char_i,
  input  logic [7:0]  item_idx_i,
  output logic [31:0] res_o
);

  localparam int AW = $clog2(BUF_DEPTH);
  localparam logic [7:0] CapLim = (BUF_DEPTH > CAP_MAX) ? 8'(CAP_MAX) : 8'(BUF_DEPTH);

  logic [7:0] text_mem_q [BUF_DEPTH];
  logic [7:0] rdata_q;

  logic [3:0] act_q;
  logic [7:0] chr_q;
  logic [7:0] idx_q;

  logic [7:0] pos_q, pos_d;
  logic [7:0] len_q, len_d;
  logic       ins_q, ins_d;
  logic [1:0] stat_q, stat_d;

  logic [7:0] src_q, src_d;
  logic [7:0] dst_q;
  logic [7:0] rem_q, rem_d;
  logic       up_q, up_d;
  logic       vld_q;

  logic [7:0]    cap;
  logic          rd_en, wr_en;
  logic [7:0]    rd_a8, wr_a8;
  logic [AW-1:0] rd_addr, wr_addr;
  logic [7:0]    wr_data;
  logic          chr_wr;
  logic [7:0]    chr_addr;
  logic [7:0]    rchar;
  logic [1:0]    stat_out;
  logic [31:0]   res_q;

  assign cap = (max_len_i > CapLim) ? CapLim : max_len_i;

  // item registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.take) begin
      act_q <= item_act_i;
      chr_q <= item_char_i;
      idx_q <= item_idx_i;
    end
  end

  // memory ports: shift reads/writes, item read, char write at commit
  assign rd_en   = (rem_q != 8'd0) | cmd_i.rd_item;
  assign rd_a8   = (rem_q != 8'd0) ? src_q : idx_q;
  assign wr_en   = vld_q | (cmd_i.commit & chr_wr);
  assign wr_a8   = vld_q ? dst_q : chr_addr;
  assign wr_data = vld_q ? rdata_q : chr_q;

  generate
    if (AW > 8) begin : g_addr_wide
      assign rd_addr = {{(AW-8){1'b0}}, rd_a8};
      assign wr_addr = {{(AW-8){1'b0}}, wr_a8};
    end else begin : g_addr_narrow
      assign rd_addr = rd_a8[AW-1:0];
      assign wr_addr = wr_a8[AW-1:0];
    end
  endgenerate

  always_ff @(posedge clk_i) begin
    if (rd_en) rdata_q <= text_mem_q[rd_addr];
    if (wr_en) text_mem_q[wr_addr] <= wr_data;
  end

  // shift engine: one read and one write per cycle; each write stores the byte that its read left in rdata_q
  always_comb begin
    src_d = src_q;
    rem_d = rem_q;
    up_d  = up_q;
    if (cmd_i.shift_start) begin
      case (cmd_i.shift_kind)
        SH_INSERT: begin
          src_d = len_q - 8'd1;
          rem_d = len_q - pos_q;
          up_d  = 1'b0;
        end
        SH_DELETE: begin
          src_d = pos_q + 8'd1;
          rem_d = len_q - pos_q - 8'd1;
          up_d  = 1'b1;
        end
        SH_BKSP: begin
          src_d = pos_q;
          rem_d = len_q - pos_q;
          up_d  = 1'b1;
        end
        default: rem_d = 8'd0;
      endcase
    end else if (rem_q != 8'd0) begin
      src_d = up_q ? src_q + 8'd1 : src_q - 8'd1;
      rem_d = rem_q - 8'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q <= 8'd0;
      vld_q <= 1'b0;
    end else begin
      rem_q <= rem_d;
      vld_q <= (rem_q != 8'd0);
    end
  end

  always_ff @(posedge clk_i) begin
    src_q <= src_d;
    up_q  <= up_d;
    if (rem_q != 8'd0) dst_q <= up_q ? src_q - 8'd1 : src_q + 8'd1;
  end

  // line state update
  always_comb begin
    pos_d    = pos_q;
    len_d    = len_q;
    ins_d    = ins_q;
    stat_d   = stat_q;
    chr_wr   = 1'b0;
    chr_addr = pos_q;
    case (cmd_i.op)
      OP_CLEAR: begin
        pos_d  = 8'd0;
        len_d  = 8'd0;
        stat_d = STAT_EDIT;
      end
      OP_APPEND: begin
        chr_wr   = 1'b1;
        chr_addr = len_q;
        len_d    = len_q + 8'd1;
        pos_d    = len_q + 8'd1;
      end
      OP_TYPE_INS: begin
        chr_wr = 1'b1;
        len_d  = len_q + 8'd1;
        pos_d  = pos_q + 8'd1;
      end
      OP_TYPE_OVR: begin
        chr_wr = 1'b1;
        pos_d  = pos_q + 8'd1;
      end
      OP_LEFT:   pos_d = pos_q - 8'd1;
      OP_RIGHT:  pos_d = pos_q + 8'd1;
      OP_HOME:   pos_d = 8'd0;
      OP_END:    pos_d = len_q;
      OP_BKSP: begin
        pos_d = pos_q - 8'd1;
        len_d = len_q - 8'd1;
      end
      OP_DEL:    len_d  = len_q - 8'd1;
      OP_TOGGLE: ins_d  = ~ins_q;
      OP_ENTER:  stat_d = STAT_ENTER;
      OP_ESC:    stat_d = STAT_ESC;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= 8'd0;
      len_q  <= 8'd0;
      ins_q  <= 1'b0;
      stat_q <= STAT_EDIT;
    end else if (cmd_i.commit) begin
      pos_q  <= pos_d;
      len_q  <= len_d;
      ins_q  <= ins_d;
      stat_q <= stat_d;
    end
  end

  // result register
  assign rchar    = ((cmd_i.op == OP_READ) && (idx_q < len_q)) ? rdata_q : 8'd0;
  assign stat_out = (cmd_i.op == OP_IGNORE) ? STAT_IGNORED : stat_d;

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) res_q <= {5'd0, stat_out, ins_d, len_d, pos_d, rchar};
  end

  assign res_o = res_q;

  always_comb begin
    sts_o.act      = act_q;
    sts_o.ch_zero  = (chr_q == 8'd0);
    sts_o.full     = (len_q >= cap);
    sts_o.at_end   = (pos_q >= len_q);
    sts_o.pos_zero = (pos_q == 8'd0);
    sts_o.done     = (stat_q != STAT_EDIT);
    sts_o.ins      = ins_q;
    sts_o.busy     = (rem_q != 8'd0) | vld_q;
    sts_o.pos      = pos_q;
    sts_o.len      = len_q;
  end

endmodule

// ===== hdl/leb_ctrl.sv =====
module leb_ctrl
  import leb_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  output logic out_valid_o,
  input  logic out_ready_i,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  fsm_e   state_q, state_d;
  op_e    op_q, op_d;
  shift_e sh_d;
  logic   out_vld_q;
  logic   out_free;

  assign out_free = ~out_vld_q | out_ready_i;

  // action decode against current line state
  always_comb begin
    op_d = OP_IGNORE;
    sh_d = SH_NONE;
    if (act_e'(sts_i.act) == ACT_CLEAR) begin
      op_d = OP_CLEAR;
    end else if (act_e'(sts_i.act) == ACT_READ) begin
      op_d = OP_READ;
    end else if (!sts_i.done) begin
      case (act_e'(sts_i.act))
        ACT_PRELOAD: begin
          if (!sts_i.ch_zero && !sts_i.full) op_d = OP_APPEND;
        end
        ACT_TYPE: begin
          if (sts_i.ch_zero) begin
            op_d = OP_IGNORE;
          end else if (sts_i.ins || sts_i.at_end) begin
            if (!sts_i.full) begin
              op_d = OP_TYPE_INS;
              sh_d = SH_INSERT;
            end
          end else begin
            op_d = OP_TYPE_OVR;
          end
        end
        ACT_LEFT:   op_d = sts_i.pos_zero ? OP_KEEP : OP_LEFT;
        ACT_RIGHT:  op_d = sts_i.at_end ? OP_KEEP : OP_RIGHT;
        ACT_HOME:   op_d = OP_HOME;
        ACT_END:    op_d = OP_END;
        ACT_BKSP: begin
          if (sts_i.pos_zero) begin
            op_d = OP_KEEP;
          end else begin
            op_d = OP_BKSP;
            sh_d = SH_BKSP;
          end
        end
        ACT_DEL: begin
          if (sts_i.at_end) begin
            op_d = OP_KEEP;
          end else begin
            op_d = OP_DEL;
            sh_d = SH_DELETE;
          end
        end
        ACT_TOGGLE: op_d = OP_TOGGLE;
        ACT_ENTER:  op_d = OP_ENTER;
        ACT_ESC:    op_d = OP_ESC;
        default:    op_d = OP_IGNORE;
      endcase
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:   if (in_valid_i) state_d = S_EXEC;
      S_EXEC:   state_d = (sh_d != SH_NONE) ? S_SHIFT : S_COMMIT;
      S_SHIFT:  if (!sts_i.busy) state_d = S_COMMIT;
      S_COMMIT: if (out_free) state_d = S_IDLE;
      default:  state_d = S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_ready_o        = 1'b0;
    cmd_o.take        = 1'b0;
    cmd_o.rd_item     = 1'b0;
    cmd_o.shift_start = 1'b0;
    cmd_o.shift_kind  = sh_d;
    cmd_o.commit      = 1'b0;
    cmd_o.op          = op_q;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.take = in_valid_i;
      end
      S_EXEC: begin
        cmd_o.rd_item     = 1'b1;
        cmd_o.shift_start = (sh_d != SH_NONE);
      end
      S_COMMIT: cmd_o.commit = out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      op_q      <= OP_IGNORE;
      out_vld_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == S_EXEC) op_q <= op_d;
      if (cmd_o.commit) out_vld_q <= 1'b1;
      else if (out_ready_i) out_vld_q <= 1'b0;
    end
  end

  assign out_valid_o = out_vld_q;

endmodule

// ===== hdl/line_edit_buffer_core.sv =====
// Line edit buffer: keystroke-level editor over a byte line store.
// Input stream (s_axis): one item per key action. tuser carries the action
// code, tdata the character and the read index. Output stream (m_axis):
// exactly one result item per input item, in order, carrying the read
// character, edit position, line length, insert mode and status.
// APB port: register 0 at byte address 0 is max_length (reset 255); write
// it only while no item is in flight.
// Sequence: an item is accepted in idle, decoded in the exec state and its
// result is registered in the commit state, after which the block returns to
// idle; no new item is accepted before then. Insert, backspace and
// delete first move the tail of the line one entry per cycle through the
// single store port pair, in a shift state between exec and commit; at
// most 254 entries move.
// Reset clears position, length, mode, status and the result valid; the
// text store itself is not cleared, nothing below the length is unwritten.
// A result waits in the output register while m_axis_tready is low; the
// block takes the next item meanwhile and holds only that item's commit.
`include "line_edit_buffer_core_defines.svh"

module line_edit_buffer_core
  import leb_pkg::*;
#(
  parameter int BUF_DEPTH = BUF_DEPTH_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input items
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // [7:0] char_code, [15:8] read_index
  input  logic [3:0]  s_axis_tuser,   // [3:0] action
  // result items
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // [7:0] read_char, [15:8] edit_position,
                                      // [23:16] line_length, [24] insert_on,
                                      // [26:25] status, [31:27] zero
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam logic [7:0] MaxLenRst = 8'(CAP_MAX);

  logic [7:0] max_len_q;
  logic       reg_hit;
  cmd_t       cmd;
  sts_t       sts;

  // register file: only max_length at word 0; paddr[1:0] ignored
  assign reg_hit = (paddr[2] == 1'b0);
  assign pready  = 1'b1;
  assign prdata  = reg_hit ? {24'd0, max_len_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_len_q <= MaxLenRst;
    end else if (psel && penable && pwrite && pready && reg_hit) begin
      max_len_q <= pwdata[7:0];
    end
  end

  leb_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  leb_dp #(
    .BUF_DEPTH (BUF_DEPTH)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .max_len_i   (max_len_q),
    .item_act_i  (s_axis_tuser),
    .item_char_i (s_axis_tdata[7:0]),
    .item_idx_i  (s_axis_tdata[15:8]),
    .res_o       (m_axis_tdata)
  );

  // edit position never runs past the end of the line
  `LEB_ASSERT_NOW(a_pos_in_line, 1'b1, sts.pos <= sts.len, "edit position past line length")
  // a commit must not overwrite a result that is still held
  `LEB_ASSERT_NOW(a_commit_free, cmd.commit, !m_axis_tvalid || m_axis_tready,
                  "result overwritten under stall")
  // no new item while the tail is being moved
  `LEB_ASSERT_NOW(a_busy_no_take, sts.busy, !s_axis_tready, "item accepted during shift")
  // every commit presents a result
  `LEB_ASSERT_NEXT(a_commit_valid, cmd.commit, m_axis_tvalid, "commit without result")

endmodule
